FILE: hdl/erma_pkg.sv
// ----------------------------------------------------------------------------
// erma_pkg
// constants and widths for the encoder rpm moving average core
// ----------------------------------------------------------------------------
package erma_pkg;

	localparam int WINDOW_LEN  = 5;
	localparam int WIN_IDX_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int TOTAL_W     = 32 + $clog2(WINDOW_LEN) + 1;

	localparam int SAMPLE_W    = 32;
	localparam int RPM_W       = 32;
	localparam int CPR_W       = 16;

	localparam int SCALE_W     = 24;
	localparam int PROD_W      = SAMPLE_W + SCALE_W;
	localparam int DEN_W       = SAMPLE_W + CPR_W;
	localparam int DIV_STEPS   = 32;
	localparam int STEP_W      = $clog2(DIV_STEPS);

	localparam int DIG_W       = WIN_IDX_W + 4;
	localparam int MEAN_DIGITS = (TOTAL_W + 3) / 4;
	localparam int MEAN_W      = 4 * MEAN_DIGITS;

	localparam logic [SCALE_W-1:0] RPM_Q8_SCALE = SCALE_W'(15360000);
	localparam logic [CPR_W-1:0]   CPR_RESET    = CPR_W'(1400);

	localparam logic signed [RPM_W-1:0] RPM_MAX = {1'b0, {(RPM_W-1){1'b1}}};
	localparam logic signed [RPM_W-1:0] RPM_MIN = {1'b1, {(RPM_W-1){1'b0}}};

endpackage

FILE: hdl/erma_if.sv
// ----------------------------------------------------------------------------
// erma channel interfaces
// valid/ready channels for samples, results and the configuration write
// ----------------------------------------------------------------------------
interface erma_sample_if;
	logic                            valid;
	logic                            ready;
	logic [erma_pkg::SAMPLE_W-1:0]   sample_count;
	logic [erma_pkg::SAMPLE_W-1:0]   sample_time_ms;

	modport source (output valid, output sample_count, output sample_time_ms, input ready);
	modport sink   (input valid, input sample_count, input sample_time_ms, output ready);
endinterface

interface erma_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [erma_pkg::RPM_W-1:0]  average_rpm_q8;
	logic signed [erma_pkg::RPM_W-1:0]  sample_rpm_q8;
	logic                               zero_interval;

	modport source (output valid, output average_rpm_q8, output sample_rpm_q8,
		output zero_interval, input ready);
	modport sink   (input valid, input average_rpm_q8, input sample_rpm_q8,
		input zero_interval, output ready);
endinterface

interface erma_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [erma_pkg::CPR_W-1:0]   counts_per_rev;

	modport source (output valid, output counts_per_rev, input ready);
	modport sink   (input valid, input counts_per_rev, output ready);
endinterface

FILE: hdl/encoder_rpm_moving_average_core.sv
// ----------------------------------------------------------------------------
// encoder_rpm_moving_average_core
// encoder speed in rpm (q.8) with a moving average over the last speeds
//
//  channel   dir   payload                                          transfer
//  samples   in    sample_count, sample_time_ms                     valid & ready
//  results   out   average_rpm_q8, sample_rpm_q8, zero_interval     valid & ready
//  cfg       in    counts_per_rev                                   valid & ready
//
//  from its transfer to a registered result a sample goes through two
//  products on one 32x24 multiplier, a 32-step shift-subtract divider for the
//  speed, then a 9-step radix-16 divide by the window length for the mean; a
//  zero interval goes straight to the mean and a saturated speed skips the
//  divider. samples.ready is high only while the
//  sequencer is idle; a finished result waits in the output register, and the
//  sequencer holds at its last step if that register is still full.
//  cfg.ready is always high. reset clears the previous sample, the window and
//  its total, and loads counts_per_rev 1400.
// ----------------------------------------------------------------------------
module encoder_rpm_moving_average_core (
	input  logic               clk,
	input  logic               arst_n,
	erma_sample_if.sink        samples,
	erma_result_if.source      results,
	erma_cfg_if.sink           cfg
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MNUM = 3'd1;
	localparam logic [2:0] S_MDEN = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_SPD  = 3'd5;
	localparam logic [2:0] S_MSET = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0]                              state_q;
	logic                                    out_valid_q;
	logic [erma_pkg::CPR_W-1:0]              cpr_q;
	logic [erma_pkg::SAMPLE_W-1:0]           prev_count_q;
	logic [erma_pkg::SAMPLE_W-1:0]           prev_time_q;
	logic signed [erma_pkg::RPM_W-1:0]       win_q [erma_pkg::WINDOW_LEN];
	logic signed [erma_pkg::TOTAL_W-1:0]     total_q;

	logic [erma_pkg::SAMPLE_W-1:0]           mag_q;
	logic [erma_pkg::SAMPLE_W-1:0]           dt_q;
	logic                                    neg_q;
	logic                                    zero_q;
	logic                                    ovf_q;
	logic                                    mean_ph_q;
	logic                                    tot_neg_q;
	logic signed [erma_pkg::RPM_W-1:0]       rpm_q;
	logic [erma_pkg::DEN_W-1:0]              den_q;
	logic [erma_pkg::DEN_W-1:0]              rem_q;
	logic [erma_pkg::SAMPLE_W-1:0]           num_q;
	logic [erma_pkg::SAMPLE_W-1:0]           quo_q;
	logic [erma_pkg::STEP_W-1:0]             step_q;
	logic [erma_pkg::MEAN_W-1:0]             mnum_q;
	logic [erma_pkg::WIN_IDX_W-1:0]          mrem_q;
	logic signed [erma_pkg::RPM_W-1:0]       avg_out_q;
	logic signed [erma_pkg::RPM_W-1:0]       rpm_out_q;
	logic                                    zero_out_q;

	logic                                    in_xfer;
	logic                                    out_xfer;
	logic                                    fin_go;
	logic [erma_pkg::SAMPLE_W-1:0]           dcount;
	logic [erma_pkg::SAMPLE_W-1:0]           dtime;
	logic [erma_pkg::CPR_W-1:0]              cpr_eff;
	logic [erma_pkg::SAMPLE_W-1:0]           mul_a;
	logic [erma_pkg::SCALE_W-1:0]            mul_b;
	logic [erma_pkg::PROD_W-1:0]             prod;
	logic [erma_pkg::DEN_W:0]                trial;
	logic [erma_pkg::DEN_W:0]                diff;
	logic                                    fits;
	logic [erma_pkg::DIG_W-1:0]              dig_t;
	logic [erma_pkg::DIG_W-1:0]              dig_r;
	logic [3:0]                              dig_q;
	logic signed [erma_pkg::RPM_W-1:0]       rpm_sat;
	logic signed [erma_pkg::TOTAL_W-1:0]     total_abs;
	logic signed [erma_pkg::RPM_W-1:0]       mean;

	assign samples.ready          = (state_q == S_IDLE);
	assign cfg.ready              = 1'b1;
	assign results.valid          = out_valid_q;
	assign results.average_rpm_q8 = avg_out_q;
	assign results.sample_rpm_q8  = rpm_out_q;
	assign results.zero_interval  = zero_out_q;

	assign in_xfer  = samples.valid && samples.ready;
	assign out_xfer = results.valid && results.ready;
	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || results.ready);

	assign dcount  = samples.sample_count - prev_count_q;
	assign dtime   = samples.sample_time_ms - prev_time_q;
	assign cpr_eff = (cpr_q == '0) ? erma_pkg::CPR_W'(1) : cpr_q;

	// shared multiplier
	always_comb begin
		if (state_q == S_MNUM) begin
			mul_a = mag_q;
			mul_b = erma_pkg::RPM_Q8_SCALE;
		end else begin
			mul_a = dt_q;
			mul_b = erma_pkg::SCALE_W'(cpr_eff);
		end
		prod = erma_pkg::PROD_W'(mul_a) * erma_pkg::PROD_W'(mul_b);
	end

	// shift-subtract divider step for the speed
	assign trial = {rem_q, num_q[erma_pkg::SAMPLE_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = !diff[erma_pkg::DEN_W];

	// mean digit step, one radix-16 quotient digit per cycle
	always_comb begin
		dig_t = {mrem_q, mnum_q[erma_pkg::MEAN_W-1 -: 4]};
		dig_q = '0;
		dig_r = dig_t;
		for (int k = 1; k < 16; k++) begin
			if (dig_t >= erma_pkg::DIG_W'(k * erma_pkg::WINDOW_LEN)) begin
				dig_q = 4'(k);
				dig_r = dig_t - erma_pkg::DIG_W'(k * erma_pkg::WINDOW_LEN);
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			rpm_sat = (ovf_q || quo_q[erma_pkg::SAMPLE_W-1]) ? erma_pkg::RPM_MIN
				: -$signed(quo_q);
		end else begin
			rpm_sat = (ovf_q || quo_q[erma_pkg::SAMPLE_W-1]) ? erma_pkg::RPM_MAX
				: $signed(quo_q);
		end
		total_abs = total_q[erma_pkg::TOTAL_W-1] ? -total_q : total_q;
		mean      = tot_neg_q ? -$signed(quo_q) : $signed(quo_q);
	end

	// control and state that reset clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			cpr_q        <= erma_pkg::CPR_RESET;
			prev_count_q <= '0;
			prev_time_q  <= '0;
			total_q      <= '0;
			for (int i = 0; i < erma_pkg::WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				cpr_q <= cfg.counts_per_rev;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						prev_count_q <= samples.sample_count;
						prev_time_q  <= samples.sample_time_ms;
						state_q      <= (dtime == '0) ? S_MSET : S_MNUM;
					end
				end
				S_MNUM: state_q <= S_MDEN;
				S_MDEN: state_q <= S_CHK;
				S_CHK: state_q <= (rem_q >= den_q) ? S_SPD : S_DIV;
				S_DIV: begin
					if (step_q == '0) begin
						state_q <= mean_ph_q ? S_FIN : S_SPD;
					end
				end
				S_SPD: begin
					for (int i = erma_pkg::WINDOW_LEN - 1; i > 0; i--) begin
						win_q[i] <= win_q[i-1];
					end
					win_q[0] <= rpm_sat;
					total_q  <= total_q
						- erma_pkg::TOTAL_W'(win_q[erma_pkg::WINDOW_LEN-1])
						+ erma_pkg::TOTAL_W'(rpm_sat);
					state_q  <= S_MSET;
				end
				S_MSET: state_q <= S_DIV;
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					neg_q  <= dcount[erma_pkg::SAMPLE_W-1];
					mag_q  <= dcount[erma_pkg::SAMPLE_W-1] ? -dcount : dcount;
					dt_q   <= dtime;
					zero_q <= (dtime == '0);
					rpm_q  <= '0;
				end
			end
			S_MNUM: begin
				rem_q <= erma_pkg::DEN_W'(prod[erma_pkg::PROD_W-1:erma_pkg::SAMPLE_W]);
				num_q <= prod[erma_pkg::SAMPLE_W-1:0];
			end
			S_MDEN: den_q <= prod[erma_pkg::DEN_W-1:0];
			S_CHK: begin
				ovf_q     <= (rem_q >= den_q);
				quo_q     <= '0;
				step_q    <= '1;
				mean_ph_q <= 1'b0;
			end
			S_DIV: begin
				if (mean_ph_q) begin
					mnum_q <= {mnum_q[erma_pkg::MEAN_W-5:0], 4'b0000};
					mrem_q <= dig_r[erma_pkg::WIN_IDX_W-1:0];
					quo_q  <= {quo_q[erma_pkg::SAMPLE_W-5:0], dig_q};
				end else begin
					if (fits) begin
						rem_q <= diff[erma_pkg::DEN_W-1:0];
					end else begin
						rem_q <= trial[erma_pkg::DEN_W-1:0];
					end
					num_q <= {num_q[erma_pkg::SAMPLE_W-2:0], 1'b0};
					quo_q <= {quo_q[erma_pkg::SAMPLE_W-2:0], fits};
				end
				step_q <= step_q - erma_pkg::STEP_W'(1);
			end
			S_SPD: rpm_q <= rpm_sat;
			S_MSET: begin
				tot_neg_q <= total_q[erma_pkg::TOTAL_W-1];
				mnum_q    <= erma_pkg::MEAN_W'($unsigned(total_abs));
				mrem_q    <= '0;
				quo_q     <= '0;
				step_q    <= erma_pkg::STEP_W'(erma_pkg::MEAN_DIGITS - 1);
				mean_ph_q <= 1'b1;
			end
			S_FIN: begin
				if (fin_go) begin
					avg_out_q  <= mean;
					rpm_out_q  <= rpm_q;
					zero_out_q <= zero_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_zero_gives_no_speed: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.zero_interval |-> results.sample_rpm_q8 == '0)
		else $error("zero interval result carries a speed");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("sample accepted while previous one in progress");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && !mean_ph_q |-> den_q != '0)
		else $error("divider running with zero divisor");
`endif

endmodule

FILE: dv/tb_encoder_rpm_moving_average_core.sv
// ----------------------------------------------------------------------------
// tb_encoder_rpm_moving_average_core
// self-checking bench for the encoder rpm moving average core: encoder
// samples go in over the sample channel with random gaps, results are taken
// with random stalls, and every result is compared against speeds and window
// means worked out in the bench from the accepted samples and the current
// counts_per_rev setting
// ----------------------------------------------------------------------------

class rpm_scoreboard;

	typedef struct {
		logic signed [erma_pkg::RPM_W-1:0] average_rpm_q8;
		logic signed [erma_pkg::RPM_W-1:0] sample_rpm_q8;
		logic                              zero_interval;
	} rpm_result_t;

	bit [erma_pkg::CPR_W-1:0]           cpr;
	bit [erma_pkg::SAMPLE_W-1:0]        last_count;
	bit [erma_pkg::SAMPLE_W-1:0]        last_time;
	logic signed [erma_pkg::RPM_W-1:0]  speeds [erma_pkg::WINDOW_LEN];
	longint                             speed_sum;
	rpm_result_t                        expected_rpm [$];
	int                                 errors;

	function new();
		cpr        = erma_pkg::CPR_RESET;
		last_count = '0;
		last_time  = '0;
		speed_sum  = 0;
		errors     = 0;
		foreach (speeds[i])
			speeds[i] = '0;
	endfunction

	function void set_cpr(bit [erma_pkg::CPR_W-1:0] value);
		cpr = value;
	endfunction

	function int pending();
		return expected_rpm.size();
	endfunction

	function logic signed [erma_pkg::RPM_W-1:0] speed_q8(bit [31:0] dcount, bit [31:0] dt);
		bit        neg;
		bit [31:0] mag32;
		bit [63:0] num;
		bit [63:0] den;
		bit [63:0] q;
		neg   = dcount[31];
		mag32 = neg ? (32'd0 - dcount) : dcount;
		num   = 64'(mag32) * 64'(erma_pkg::RPM_Q8_SCALE);
		den   = 64'((cpr == '0) ? 16'd1 : cpr) * 64'(dt);
		q     = num / den;
		if (neg) begin
			if (q >= 64'h8000_0000)
				return erma_pkg::RPM_MIN;
			return -$signed(q[31:0]);
		end
		if (q > 64'h7FFF_FFFF)
			return erma_pkg::RPM_MAX;
		return $signed(q[31:0]);
	endfunction

	function void note_sample(bit [31:0] cnt, bit [31:0] tms);
		bit [31:0]   dcount;
		bit [31:0]   dt;
		rpm_result_t r;
		longint      mean;
		dcount = cnt - last_count;
		dt     = tms - last_time;
		r.sample_rpm_q8 = '0;
		r.zero_interval = 1'b0;
		if (dt == '0) begin
			r.zero_interval = 1'b1;
		end else begin
			r.sample_rpm_q8 = speed_q8(dcount, dt);
			speed_sum -= longint'(speeds[erma_pkg::WINDOW_LEN-1]);
			for (int i = erma_pkg::WINDOW_LEN - 1; i > 0; i--)
				speeds[i] = speeds[i-1];
			speeds[0] = r.sample_rpm_q8;
			speed_sum += longint'(r.sample_rpm_q8);
		end
		last_count = cnt;
		last_time  = tms;
		mean = speed_sum / longint'(erma_pkg::WINDOW_LEN);
		r.average_rpm_q8 = mean[31:0];
		expected_rpm.push_back(r);
	endfunction

	function void check_result(logic signed [erma_pkg::RPM_W-1:0] avg,
			logic signed [erma_pkg::RPM_W-1:0] spd, logic zero);
		rpm_result_t r;
		if (expected_rpm.size() == 0) begin
			$error("result transfer with no sample outstanding");
			errors++;
			return;
		end
		r = expected_rpm.pop_front();
		if (avg !== r.average_rpm_q8) begin
			$error("average_rpm_q8: expected %0d, actual %0d", r.average_rpm_q8, avg);
			errors++;
		end
		if (spd !== r.sample_rpm_q8) begin
			$error("sample_rpm_q8: expected %0d, actual %0d", r.sample_rpm_q8, spd);
			errors++;
		end
		if (zero !== r.zero_interval) begin
			$error("zero_interval: expected %0b, actual %0b", r.zero_interval, zero);
			errors++;
		end
	endfunction

endclass

module tb_encoder_rpm_moving_average_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int DIR_ITEMS   = 20;

	logic clk = 1'b0;
	logic arst_n;

	erma_sample_if smp ();
	erma_result_if res ();
	erma_cfg_if    cfg_ch ();

	rpm_scoreboard sb = new();

	bit        calm = 1'b0;
	bit [31:0] enc_pos  = '0;
	bit [31:0] enc_tick = '0;

	encoder_rpm_moving_average_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp),
		.results (res),
		.cfg     (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_sample(input bit [31:0] c, input bit [31:0] t);
		smp.valid          <= 1'b1;
		smp.sample_count   <= c;
		smp.sample_time_ms <= t;
		do @(posedge clk); while (smp.ready !== 1'b1);
		sb.note_sample(c, t);
		enc_pos  = c;
		enc_tick = t;
		if (!calm && $urandom_range(0, 3) == 0) begin
			smp.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		smp.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_cpr(input bit [erma_pkg::CPR_W-1:0] value);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.counts_per_rev <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		sb.set_cpr(value);
	endtask

	// mostly plausible shaft motion, plus timer wraps, stalls and junk
	task automatic send_random_sample();
		int        pick;
		int        step;
		bit [31:0] c;
		bit [31:0] t;
		pick = $urandom_range(0, 99);
		c    = enc_pos;
		t    = enc_tick;
		if (pick < 65) begin
			step = $urandom_range(0, 6000) - 3000;
			c    = enc_pos + 32'(step);
			t    = enc_tick + 32'($urandom_range(1, 1500));
		end else if (pick < 73) begin
			step = $urandom_range(0, 2000000) - 1000000;
			c    = enc_pos + 32'(step);
			t    = enc_tick + 32'($urandom_range(1, 20));
		end else if (pick < 81) begin
			c = enc_pos + 32'($urandom_range(0, 50));
		end else if (pick < 86) begin
			c = enc_pos + 32'($urandom_range(0, 3000));
			t = 32'hFFFF_FFFF - 32'($urandom_range(0, 800));
		end else if (pick < 91) begin
			c = $urandom();
			t = enc_tick + 32'd1;
		end else begin
			c = $urandom();
			t = $urandom();
		end
		send_sample(c, t);
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
			sb.check_result(res.average_rpm_q8, res.sample_rpm_q8, res.zero_interval);
	end

	initial begin
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (calm) begin
				res.ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				res.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	initial begin
		bit [31:0]                dir_count [DIR_ITEMS];
		bit [31:0]                dir_time [DIR_ITEMS];
		bit [erma_pkg::CPR_W-1:0] cpr_plan [PHASES];

		dir_count = '{
			32'd100, 32'd100, 32'd5000, 32'd4000, 32'hFFFF_FFFF,
			32'h7FFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0, 32'd0,
			32'd1400, 32'd2800, 32'd4200, 32'd5600, 32'd7000,
			32'd8400, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_AAAA};
		dir_time = '{
			32'd1000, 32'd1000, 32'd1000, 32'd2000, 32'd2001,
			32'd2002, 32'd2003, 32'hFFFF_FFFF, 32'd5, 32'd5,
			32'd1005, 32'd2005, 32'd3005, 32'd4005, 32'd5005,
			32'd6005, 32'd6006, 32'd6007, 32'hFFFF_FFFE, 32'hAAAA_5555};

		arst_n                = 1'b0;
		smp.valid            <= 1'b0;
		smp.sample_count     <= '0;
		smp.sample_time_ms   <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.counts_per_rev <= '0;

		cpr_plan = '{16'd1, 16'd65535, 16'd0, 16'd360,
			16'($urandom_range(2, 65534)), 16'd1400,
			16'($urandom_range(2, 4096)), 16'd2048};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_count[i])
			send_sample(dir_count[i], dir_time[i]);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_cpr(cpr_plan[p]);
			if (p == PHASES - 1)
				calm = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == PHASE_ITEMS / 2)
					wait_drained();
				send_random_sample();
			end
		end

		wait_drained();
		repeat (150) @(posedge clk);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: sim.f
hdl/erma_pkg.sv
hdl/erma_if.sv
hdl/encoder_rpm_moving_average_core.sv
dv/tb_encoder_rpm_moving_average_core.sv
